FILE: hw/rtl/hgcs_pkg.sv
// Package for the horizontal gradient colour stepper.
// Constants, controller/datapath command and status types, channel helpers.
// No dependencies.
`timescale 1ns / 1ps

package hgcs_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int NUM_CHAN  = 4;
    localparam int FRAC_BITS = 16;
    localparam int CHAN_MAX  = 255 * 65536;

    // width register holds 1..MAX_WIDTH, column index 0..MAX_WIDTH-1
    localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int IDX_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // |end - start| << 16 fits in 24 bits; one quotient bit per divider step
    localparam int DIV_BITS = 8 + FRAC_BITS;
    localparam int CNT_BITS = $clog2(DIV_BITS);

    typedef struct packed {
        logic load;       // capture request, set up divider lanes
        logic div_step;   // one restoring-division step in every lane
        logic fix_step;   // apply sign to quotients, write step registers
        logic emit_col;   // load one column item into the output register
        logic emit_err;   // load the error item into the output register
    } hgcs_cmd_t;

    typedef struct packed {
        logic bad;        // incoming request is invalid
        logic slot_free;  // output register can take an item this cycle
        logic last;       // current column is the final one
    } hgcs_status_t;

    // channel n of an ARGB word: 0 = alpha, 1 = red, 2 = green, 3 = blue
    function automatic logic [7:0] channel_of(input logic [31:0] colour, input int n);
        logic [7:0] c;
        case (n)
            0:       c = colour[31:24];
            1:       c = colour[23:16];
            2:       c = colour[15:8];
            default: c = colour[7:0];
        endcase
        return c;
    endfunction

    function automatic logic [7:0] clamp_channel(input logic signed [31:0] acc);
        logic [7:0] c;
        if (acc < 0)
            c = 8'd0;
        else if (acc > CHAN_MAX)
            c = 8'd255;
        else
            c = acc[23:16];
        return c;
    endfunction

endpackage

FILE: hw/rtl/hgcs_req_if.sv
// Request channel: valid/ready plus one gradient request.
// No dependencies.
`timescale 1ns / 1ps

interface hgcs_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] start_x;
    logic signed [15:0] span_width;
    logic signed [15:0] span_height;
    logic        [31:0] colour_start;
    logic        [31:0] colour_end;

    modport source (
        output valid, start_x, span_width, span_height, colour_start, colour_end,
        input  ready
    );
    modport sink (
        input  valid, start_x, span_width, span_height, colour_start, colour_end,
        output ready
    );
endinterface

FILE: hw/rtl/hgcs_col_if.sv
// Column result channel: valid/ready plus one column item.
// No dependencies.
`timescale 1ns / 1ps

interface hgcs_col_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] column_x;
    logic        [31:0] column_colour;
    logic               last_column;
    logic               bad_request;

    modport source (
        output valid, column_x, column_colour, last_column, bad_request,
        input  ready
    );
    modport sink (
        input  valid, column_x, column_colour, last_column, bad_request,
        output ready
    );
endinterface

FILE: hw/rtl/hgcs_datapath.sv
// Datapath: request capture, four restoring-divider lanes, accumulators,
// column counter and the output register. Uses hgcs_pkg and both channel interfaces.
`timescale 1ns / 1ps

module hgcs_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    hgcs_req_if.sink              request,
    hgcs_col_if.source            column,
    input  hgcs_pkg::hgcs_cmd_t    cmd,
    output hgcs_pkg::hgcs_status_t status
);
    import hgcs_pkg::*;

    logic signed [15:0]         sx_reg;
    logic        [W_BITS-1:0]   w_reg;
    logic        [IDX_BITS-1:0] idx_reg, idx_next;
    logic        [W_BITS-1:0]   w_m1;

    logic signed [31:0]         acc_reg  [NUM_CHAN];
    logic signed [31:0]         acc_next [NUM_CHAN];
    logic signed [31:0]         step_reg  [NUM_CHAN];
    logic signed [31:0]         step_next [NUM_CHAN];
    logic        [DIV_BITS-1:0] dvd_reg  [NUM_CHAN];
    logic        [DIV_BITS-1:0] dvd_next [NUM_CHAN];
    logic        [W_BITS-1:0]   rem_reg  [NUM_CHAN];
    logic        [W_BITS-1:0]   rem_next [NUM_CHAN];
    logic        [NUM_CHAN-1:0] neg_reg, neg_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [16:0] out_x_reg, out_x_next;
    logic        [31:0] out_colour_reg, out_colour_next;
    logic               out_last_reg, out_last_next;
    logic               out_bad_reg, out_bad_next;

    logic [31:0] colour_now;

    assign status.bad = (request.span_width <= 16'sd0) || (request.span_height <= 16'sd0)
                     || (request.span_width > 16'(MAX_WIDTH));
    assign status.slot_free = !out_valid_reg || column.ready;
    assign w_m1 = w_reg - W_BITS'(1);
    assign status.last = (idx_reg == w_m1[IDX_BITS-1:0]);

    always_comb
    begin
        logic [7:0]  a, b;
        logic [8:0]  sh;
        logic [W_BITS:0] trial;
        for (int n = 0; n < NUM_CHAN; n++)
        begin
            acc_next[n]  = acc_reg[n];
            step_next[n] = step_reg[n];
            dvd_next[n]  = dvd_reg[n];
            rem_next[n]  = rem_reg[n];
            neg_next[n]  = neg_reg[n];
            a = channel_of(request.colour_start, n);
            b = channel_of(request.colour_end, n);
            sh = '0;
            trial = '0;
            if (cmd.load)
            begin
                acc_next[n] = {8'd0, a, 16'd0};
                neg_next[n] = (b < a);
                dvd_next[n] = (b < a) ? {a - b, 16'd0} : {b - a, 16'd0};
                rem_next[n] = '0;
            end
            else if (cmd.div_step)
            begin
                // shift in next dividend bit, subtract divisor when it fits
                sh = 9'({rem_reg[n], dvd_reg[n][DIV_BITS-1]});
                trial = (W_BITS+1)'(sh);
                if (trial >= {1'b0, w_reg})
                begin
                    rem_next[n] = W_BITS'(trial - {1'b0, w_reg});
                    dvd_next[n] = {dvd_reg[n][DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[n] = W_BITS'(trial);
                    dvd_next[n] = {dvd_reg[n][DIV_BITS-2:0], 1'b0};
                end
            end
            else if (cmd.fix_step)
            begin
                step_next[n] = neg_reg[n] ? -$signed(32'(dvd_reg[n]))
                                          :  $signed(32'(dvd_reg[n]));
            end
            else if (cmd.emit_col)
            begin
                acc_next[n] = acc_reg[n] + step_reg[n];
            end
        end
    end

    always_comb
    begin
        colour_now = '0;
        for (int n = 0; n < NUM_CHAN; n++)
            colour_now[31 - 8*n -: 8] = clamp_channel(acc_reg[n]);
    end

    always_comb
    begin
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_x_next      = out_x_reg;
        out_colour_next = out_colour_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;
        if (column.ready)
            out_valid_next = 1'b0;
        if (cmd.load)
            idx_next = '0;
        if (cmd.emit_col)
        begin
            idx_next        = idx_reg + IDX_BITS'(1);
            out_valid_next  = 1'b1;
            out_x_next      = {sx_reg[15], sx_reg} + 17'(idx_reg);
            out_colour_next = colour_now;
            out_last_next   = status.last;
            out_bad_next    = 1'b0;
        end
        else if (cmd.emit_err)
        begin
            out_valid_next  = 1'b1;
            out_x_next      = '0;
            out_colour_next = '0;
            out_last_next   = 1'b1;
            out_bad_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg <= request.start_x;
            w_reg  <= request.span_width[W_BITS-1:0];
        end
        for (int n = 0; n < NUM_CHAN; n++)
        begin
            acc_reg[n]  <= acc_next[n];
            step_reg[n] <= step_next[n];
            dvd_reg[n]  <= dvd_next[n];
            rem_reg[n]  <= rem_next[n];
        end
        neg_reg        <= neg_next;
        out_x_reg      <= out_x_next;
        out_colour_reg <= out_colour_next;
        out_last_reg   <= out_last_next;
        out_bad_reg    <= out_bad_next;
    end

    assign column.valid         = out_valid_reg;
    assign column.column_x      = out_x_reg;
    assign column.column_colour = out_colour_reg;
    assign column.last_column   = out_last_reg;
    assign column.bad_request   = out_bad_reg;

endmodule

FILE: hw/rtl/hgcs_controller.sv
// Controller: sequences request capture, the divide steps and column emission.
// Uses hgcs_pkg; drives the datapath through hgcs_cmd_t.
`timescale 1ns / 1ps

module hgcs_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    output logic                  ready,
    input  hgcs_pkg::hgcs_status_t status,
    output hgcs_pkg::hgcs_cmd_t    cmd
);
    import hgcs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_EMIT,
        S_ERR
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                accept;

    assign ready  = (state_reg == S_IDLE);
    assign accept = valid && ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.bad)
                        state_next = S_ERR;
                    else
                    begin
                        cmd.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(DIV_BITS - 1))
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.fix_step = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_col = 1'b1;
                    if (status.last)
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/horizontal_gradient_colour_stepper.sv
// Top level of the horizontal gradient colour stepper.
// Joins hgcs_controller and hgcs_datapath; uses hgcs_pkg, hgcs_req_if, hgcs_col_if.
//
// Usage:
//   request: one item per gradient (start_x, span_width, span_height,
//            colour_start, colour_end), valid/ready handshake.
//   column:  span_width items, one per column, the last one flagged with
//            last_column. A request with width or height not positive, or a
//            width above MAX_WIDTH, gives one item with bad_request and
//            last_column set, column_x and column_colour zero.
//   Sequence: accept, the divide steps (one quotient bit per cycle, four channel
//   lanes in parallel), a step that signs the steps, then one column per
//   cycle while the output register can take an item.
//   request.ready is high only while idle; the final column may still sit in
//   the output register when the next request is accepted.
//   A stalled column.ready holds the output register and pauses emission;
//   no item is dropped.
//   Reset clears the controller and the output valid; the block comes up idle.
`timescale 1ns / 1ps

module horizontal_gradient_colour_stepper (
    input  logic       clk,
    input  logic       rst_n,
    hgcs_req_if.sink   request,
    hgcs_col_if.source column
);
    import hgcs_pkg::*;

    hgcs_cmd_t    cmd;
    hgcs_status_t status;
    logic         ready;

    assign request.ready = ready;

    hgcs_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (request.valid),
        .ready  (ready),
        .status (status),
        .cmd    (cmd)
    );

    hgcs_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .column  (column),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

FILE: dv/tb_horizontal_gradient_colour_stepper.sv
// Testbench for horizontal_gradient_colour_stepper: directed and random gradient
// requests, random stalls on both channels, per-column prediction and checking.
// Depends on hgcs_pkg, hgcs_req_if, hgcs_col_if and the RTL top level.
`timescale 1ns / 1ps

module tb_horizontal_gradient_colour_stepper;
    import hgcs_pkg::*;

    localparam int RANDOM_REQUESTS = 241;
    localparam int DRAIN_EVERY     = 64;
    localparam int SETTLE_CYCLES   = 100;

    typedef struct {
        logic signed [15:0] start_x;
        logic signed [15:0] span_width;
        logic signed [15:0] span_height;
        logic        [31:0] colour_start;
        logic        [31:0] colour_end;
        bit                 drain_first;  // hold off until all columns are back
    } gradient_req_t;

    typedef struct {
        logic signed [16:0] x;
        logic        [31:0] colour;
        logic               last;
        logic               bad;
    } column_item_t;

    logic clk;
    logic rst_n;

    hgcs_req_if request_bus ();
    hgcs_col_if column_bus ();

    horizontal_gradient_colour_stepper DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_bus),
        .column  (column_bus)
    );

    gradient_req_t pending_requests[$];
    column_item_t  expected_columns[$];

    int  request_total   = 0;
    int  accepted_count  = 0;
    int  rejected_count  = 0;
    int  column_count    = 0;
    int  mismatch_count  = 0;
    int  send_gap        = 0;
    int  recv_stall      = 0;
    int  cycle_count     = 0;
    bit  no_idle         = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n                    = 1'b0;
        request_bus.valid        = 1'b0;
        request_bus.start_x      = '0;
        request_bus.span_width   = '0;
        request_bus.span_height  = '0;
        request_bus.colour_start = '0;
        request_bus.colour_end   = '0;
        column_bus.ready         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // idle stretches alternate with stretches of full throughput
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[7:0] == 8'd0)
            no_idle <= ($urandom_range(0, 3) == 0);
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 31);
        if (no_idle)
            return 0;
        if (r < 16)
            return 0;
        if (r < 28)
            return $urandom_range(1, 3);
        if (r < 31)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t column mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Works out the column items of one accepted request.
    task automatic predict_gradient(input gradient_req_t r);
        int           acc [NUM_CHAN];
        int           step [NUM_CHAN];
        int           w;
        int           h;
        logic [7:0]   ch;
        column_item_t c;
        w = r.span_width;
        h = r.span_height;
        if (w <= 0 || h <= 0 || w > MAX_WIDTH)
        begin
            c.x      = '0;
            c.colour = '0;
            c.last   = 1'b1;
            c.bad    = 1'b1;
            expected_columns.push_back(c);
            rejected_count++;
            return;
        end
        for (int n = 0; n < NUM_CHAN; n++)
        begin
            acc[n]  = int'({24'd0, r.colour_start[31 - 8 * n -: 8]}) * 65536;
            step[n] = (int'({24'd0, r.colour_end[31 - 8 * n -: 8]}) * 65536 - acc[n]) / w;
        end
        for (int i = 0; i < w; i++)
        begin
            c.colour = '0;
            for (int n = 0; n < NUM_CHAN; n++)
            begin
                if (acc[n] < 0)
                    ch = 8'd0;
                else if (acc[n] > CHAN_MAX)
                    ch = 8'hFF;
                else
                    ch = 8'(acc[n] >>> FRAC_BITS);
                c.colour[31 - 8 * n -: 8] = ch;
                acc[n] += step[n];
            end
            c.x    = 17'(int'(r.start_x) + i);
            c.last = (i == w - 1);
            c.bad  = 1'b0;
            expected_columns.push_back(c);
        end
    endtask

    task automatic queue_request(input int sx, input int w, input int h,
                                 input logic [31:0] c0, input logic [31:0] c1,
                                 input bit drain);
        gradient_req_t r;
        r.start_x      = 16'(sx);
        r.span_width   = 16'(w);
        r.span_height  = 16'(h);
        r.colour_start = c0;
        r.colour_end   = c1;
        r.drain_first  = drain;
        pending_requests.push_back(r);
        request_total++;
    endtask

    // channels forced to 00 or FF now and then, to hit the clamp corners
    function automatic logic [31:0] pick_colour();
        logic [31:0] c;
        c = $urandom;
        if ($urandom_range(0, 3) == 0)
            for (int n = 0; n < 4; n++)
                c[8 * n +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return c;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_bus.valid <= 1'b0;
            send_gap          <= 0;
        end
        else
        begin : drive
            gradient_req_t r;
            if (request_bus.valid && request_bus.ready)
            begin
                r.start_x      = request_bus.start_x;
                r.span_width   = request_bus.span_width;
                r.span_height  = request_bus.span_height;
                r.colour_start = request_bus.colour_start;
                r.colour_end   = request_bus.colour_end;
                r.drain_first  = 1'b0;
                predict_gradient(r);
                accepted_count++;
            end
            if (!request_bus.valid || request_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap          <= send_gap - 1;
                    request_bus.valid <= 1'b0;
                end
                else if (pending_requests.size() == 0)
                    request_bus.valid <= 1'b0;
                else if (pending_requests[0].drain_first && expected_columns.size() != 0)
                    request_bus.valid <= 1'b0;
                else
                begin
                    r = pending_requests.pop_front();
                    request_bus.start_x      <= r.start_x;
                    request_bus.span_width   <= r.span_width;
                    request_bus.span_height  <= r.span_height;
                    request_bus.colour_start <= r.colour_start;
                    request_bus.colour_end   <= r.colour_end;
                    request_bus.valid        <= 1'b1;
                    send_gap                 <= pick_idle();
                end
            end
        end
    end

    // column receiver: ready with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_bus.ready <= 1'b0;
            recv_stall       <= 0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall       <= recv_stall - 1;
            column_bus.ready <= 1'b0;
        end
        else
        begin
            column_bus.ready <= 1'b1;
            recv_stall       <= pick_idle();
        end
    end

    // column monitor
    always @(posedge clk)
    begin : column_check
        column_item_t want;
        if (rst_n && column_bus.valid && column_bus.ready)
        begin
            if (expected_columns.size() == 0)
                report_mismatch("unexpected item", column_bus.column_colour, 32'd0);
            else
            begin
                want = expected_columns.pop_front();
                if (!want.bad)
                    column_count++;
                if (column_bus.column_x !== want.x)
                    report_mismatch("column_x", 32'(column_bus.column_x), 32'(want.x));
                if (column_bus.column_colour !== want.colour)
                    report_mismatch("column_colour", column_bus.column_colour, want.colour);
                if (column_bus.last_column !== want.last)
                    report_mismatch("last_column", 32'(column_bus.last_column), 32'(want.last));
                if (column_bus.bad_request !== want.bad)
                    report_mismatch("bad_request", 32'(column_bus.bad_request), 32'(want.bad));
            end
        end
    end

    initial
    begin
        int w;
        int h;
        int sel;

        // directed: field extremes and the rejection cases
        queue_request(0,      1,      1,      32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_request(-32768, 64,     32767,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_request(32767,  64,     1,      32'h1234_5678, 32'h8765_4321, 1'b0);
        queue_request(5,      0,      5,      32'hDEAD_BEEF, 32'h0000_0000, 1'b0);
        queue_request(5,      -1,     5,      32'hDEAD_BEEF, 32'h0000_0000, 1'b0);
        queue_request(-1,     -32768, 5,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_request(100,    65,     10,     32'h0102_0304, 32'hF0E0_D0C0, 1'b0);
        queue_request(100,    32767,  32767,  32'h0102_0304, 32'hF0E0_D0C0, 1'b0);
        queue_request(7,      10,     0,      32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        queue_request(7,      10,     -32768, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        queue_request(7,      10,     -1,     32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        queue_request(-32768, -32768, -32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_request(3,      3,      2,      32'h80FF_00FF, 32'h80FF_00FF, 1'b0);
        queue_request(-200,   7,      9,      32'hFF00_0000, 32'h00FF_FFFF, 1'b0);
        queue_request(0,      64,     1,      32'h0000_0000, 32'h0101_0101, 1'b0);
        queue_request(0,      2,      1,      32'hFF00_FF00, 32'h00FF_00FF, 1'b0);
        queue_request(-1,     63,     100,    32'h3C5A_96E1, 32'hC3A5_691E, 1'b0);
        queue_request(32767,  32,     1,      32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
        queue_request(12,     64,     32767,  32'hFFFF_FFFF, 32'hFEFE_FEFE, 1'b0);

        // random: mostly well-formed, narrow spans, with some bad requests
        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            sel = $urandom_range(0, 15);
            w   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            h   = $urandom_range(1, 32767);
            if (sel == 0)
                w = int'($signed(16'($urandom)));
            else if (sel == 1)
                w = $urandom_range(0, 1) ? 0 : -$urandom_range(1, 32768);
            else if (sel == 2)
                w = $urandom_range(65, 32767);
            else if (sel == 3)
                h = $urandom_range(0, 1) ? 0 : -$urandom_range(1, 32768);
            queue_request(int'($signed(16'($urandom))), w, h, pick_colour(), pick_colour(),
                          (k % DRAIN_EVERY) == 0);
        end

        do
            @(negedge clk);
        while (accepted_count != request_total || expected_columns.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d gradient requests (%0d rejected); checked %0d column items.",
                 accepted_count, rejected_count, column_count);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && expected_columns.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Timeout: %0d of %0d requests accepted, %0d columns outstanding",
                 accepted_count, request_total, expected_columns.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: horizontal_gradient_colour_stepper.f
hw/rtl/hgcs_pkg.sv
hw/rtl/hgcs_req_if.sv
hw/rtl/hgcs_col_if.sv
hw/rtl/hgcs_datapath.sv
hw/rtl/hgcs_controller.sv
hw/rtl/horizontal_gradient_colour_stepper.sv
dv/tb_horizontal_gradient_colour_stepper.sv
